FILE: design/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 232;
   localparam int CSR_ADDR_W = 3;
   localparam int SQ_W       = 50;
   localparam int ROOT_W     = 25;
   localparam int REM_W      = 28;

   localparam logic        REG_VIEW_W   = 1'b0;
   localparam logic        REG_VIEW_H   = 1'b1;
   localparam logic [10:0] VIEW_W_RESET = 11'd1024;
   localparam logic [10:0] VIEW_H_RESET = 11'd768;

   localparam logic [4:0] SQRT_STEPS = 5'd25;
   localparam logic [4:0] DIV_STEPS  = 5'd17;

   localparam logic [3:0] MASK_NONE     = 4'h0;
   localparam logic [3:0] MASK_FRINGE_A = 4'h3;
   localparam logic [3:0] MASK_FRINGE_C = 4'hC;
   localparam logic [3:0] MASK_FRINGE_B = 4'h6;

   typedef enum logic [1:0] {
      KIND_FILL    = 2'd0,
      KIND_OUTLINE = 2'd1,
      KIND_LINE    = 2'd2,
      KIND_TEXT    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_RECT, ST_MUL, ST_SQRT, ST_DIVX, ST_DIVY, ST_LINE
   } state_type;

   typedef enum logic {
      OP_SQRT,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic signed [17:0] x0;
      logic signed [17:0] y0;
      logic signed [17:0] x1;
      logic signed [17:0] y1;
   } box_type;

   function automatic logic [15:0] sat_coord(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'h7fff;
      end else if (v < -19'sd32768) begin
         return 16'h8000;
      end else begin
         return v[15:0];
      end
   endfunction

   // scale down by 16 bits, round to nearest, ties away from zero
   function automatic logic signed [16:0] round_off(input logic signed [31:0] v);
      logic [31:0]        mag;
      logic [31:0]        sh;
      logic signed [16:0] m;
      mag = v[31] ? 32'(-v) : 32'(v);
      sh  = (mag + 32'h0000_8000) >> 16;
      m   = $signed(sh[16:0]);
      return v[31] ? -m : m;
   endfunction

   function automatic logic [15:0] corner(input logic [15:0] base,
                                          input logic signed [16:0] off,
                                          input logic neg);
      logic signed [18:0] b;
      logic signed [18:0] o;
      b = 19'($signed(base));
      o = 19'(off);
      if (neg) begin
         o = -o;
      end
      return sat_coord(b + o);
   endfunction

endpackage
`default_nettype wire

FILE: design/cdq_arith.sv
`default_nettype none
module cdq_arith (
   input  logic                        clock,
   input  logic                        reset,
   input  cdq_pkg::arith_ctl_type      ctl,
   input  logic [cdq_pkg::SQ_W-1:0]    num,
   input  logic [cdq_pkg::ROOT_W-1:0]  den,
   output logic                        done,
   output logic [cdq_pkg::ROOT_W-1:0]  result
);
   import cdq_pkg::*;

   arith_op_type      op_ff, op_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [SQ_W-1:0]   shift_ff, shift_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W-1:0] den_ff, den_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  trial_a;
   logic [REM_W-1:0]  trial_b;
   logic [REM_W:0]    diff;
   logic [SQ_W-1:0]   shift_next;
   logic              ge;

   // one shared subtract/compare: two bits of radicand or one numerator bit per step
   always_comb begin
      if (op_ff == OP_SQRT) begin
         trial_a    = {rem_ff[REM_W-3:0], shift_ff[SQ_W-1:SQ_W-2]};
         trial_b    = {1'b0, root_ff, 2'b01};
         shift_next = shift_ff << 2;
      end else begin
         trial_a    = {rem_ff[REM_W-2:0], shift_ff[SQ_W-1]};
         trial_b    = {3'b000, den_ff};
         shift_next = shift_ff << 1;
      end
      diff = {1'b0, trial_a} - {1'b0, trial_b};
      ge   = !diff[REM_W];
   end

   always_comb begin
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         op_in   = ctl.op;
         den_in  = den;
         root_in = '0;
         if (ctl.op == OP_SQRT) begin
            cnt_in   = SQRT_STEPS;
            rem_in   = '0;
            shift_in = num;
         end else begin
            cnt_in   = DIV_STEPS;
            rem_in   = {5'b0, num[39:17]};
            shift_in = {num[16:0], 33'b0};
         end
      end else if (cnt_ff != 5'd0) begin
         rem_in   = ge ? diff[REM_W-1:0] : trial_a;
         root_in  = {root_ff[ROOT_W-2:0], ge};
         shift_in = shift_next;
         cnt_in   = cnt_ff - 5'd1;
         done_in  = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= OP_SQRT;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      den_ff   <= den_in;
   end

   assign done   = done_ff;
   assign result = root_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> cnt_ff == 5'd0)
      else $error("arith started while busy");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> cnt_ff == 5'd0 && $past(cnt_ff) == 5'd1)
      else $error("arith done out of sequence");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SQRT_STEPS)
      else $error("arith step count out of range");

endmodule
`default_nettype wire

FILE: design/draw_command_quad_expander_core.sv
`default_nettype none
// Rectangles: accept, a setup state, then one quad per cycle while the output is not
// stalled (up to four bars). Lines: two squarings, 25 square-root steps and two
// 17-step divides on the shared subtract unit, six products on the one multiplier,
// then 1 or 5 quads.
// The next command is taken once the last quad is issued.
// Synchronous active-high reset clears the sequencer, output valid, open batch
// and restores the viewport to 1024 x 768.
module draw_command_quad_expander_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // first_x, first_y, second_x, second_y, clip_min_x, clip_min_y, clip_max_x,
   // clip_max_y, stroke_width, feather_width, tint_rgba
   input  logic [cdq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd_kind
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // vert_a, vert_b, vert_c, vert_d, transparent_mask, quad_color,
   // batch_clip_min, batch_clip_max, zero pad
   output logic [cdq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // new_batch
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import cdq_pkg::*;

   state_type                state_ff, state_in;
   logic [REQ_DATA_W-1:0]    in_ff, in_in;
   kind_type                 kind_ff, kind_in;
   logic [15:0]              ecx0_ff, ecy0_ff, ecx1_ff, ecy1_ff;
   logic [15:0]              ecx0_in, ecy0_in, ecx1_in, ecy1_in;
   logic [3:0]               mask_ff, mask_in;
   logic [15:0]              ax_ff, ay_ff, ax_in, ay_in;
   logic                     sgnx_ff, sgny_ff, sgnx_in, sgny_in;
   logic [2:0]               step_ff, step_in;
   logic [32:0]              sq_ff, sq_in;
   logic [ROOT_W-1:0]        r_ff, r_in;
   logic signed [16:0]       dirx_ff, diry_ff, dirx_in, diry_in;
   logic [31:0]              prod_ff [0:5];
   logic [31:0]              prod_in [0:5];
   logic [2:0]               qidx_ff, qidx_in;
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]    out_data_ff, out_data_in;
   logic                     out_nb_ff, out_nb_in;
   logic                     out_last_ff, out_last_in;
   logic [63:0]              cur_clip_ff, cur_clip_in;
   logic                     batch_open_ff, batch_open_in;
   logic [10:0]              vw_ff, vh_ff, vw_in, vh_in;

   arith_ctl_type            arith_ctl;
   logic [SQ_W-1:0]          arith_num;
   logic [ROOT_W-1:0]        arith_den;
   logic                     arith_done;
   logic [ROOT_W-1:0]        arith_result;

   cdq_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .num    (arith_num),
      .den    (arith_den),
      .done   (arith_done),
      .result (arith_result)
   );

   // latched command fields
   logic [15:0] fx, fy, gx, gy, cx0, cy0, cx1, cy1;
   logic [11:0] tw, fw;
   logic [31:0] tint;
   assign fx   = in_ff[15:0];
   assign fy   = in_ff[31:16];
   assign gx   = in_ff[47:32];
   assign gy   = in_ff[63:48];
   assign cx0  = in_ff[79:64];
   assign cy0  = in_ff[95:80];
   assign cx1  = in_ff[111:96];
   assign cy1  = in_ff[127:112];
   assign tw   = in_ff[139:128];
   assign fw   = in_ff[151:140];
   assign tint = in_ff[183:152];

   function automatic box_type bar_box(input kind_type k, input logic [1:0] idx,
                                       input logic [15:0] x0, input logic [15:0] y0,
                                       input logic [15:0] x1, input logic [15:0] y1,
                                       input logic [11:0] t);
      box_type            b;
      logic signed [17:0] ax0, ay0, ax1, ay1, tt;
      ax0  = 18'($signed(x0));
      ay0  = 18'($signed(y0));
      ax1  = 18'($signed(x1));
      ay1  = 18'($signed(y1));
      tt   = $signed({6'b0, t});
      b.x0 = ax0;
      b.y0 = ay0;
      b.x1 = ax1;
      b.y1 = ay1;
      if (k != KIND_FILL) begin
         case (idx)
            2'd0: b.y1 = ay0 + tt;
            2'd1: b.y0 = ay1 - tt;
            2'd2: b.x1 = ax0 + tt;
            2'd3: b.x0 = ax1 - tt;
            default: b.x0 = ax0;
         endcase
      end
      return b;
   endfunction

   function automatic box_type clip_to(input box_type b, input logic [15:0] c0x,
                                       input logic [15:0] c0y, input logic [15:0] c1x,
                                       input logic [15:0] c1y);
      box_type            r;
      logic signed [17:0] kx0, ky0, kx1, ky1;
      kx0  = 18'($signed(c0x));
      ky0  = 18'($signed(c0y));
      kx1  = 18'($signed(c1x));
      ky1  = 18'($signed(c1y));
      r.x0 = (b.x0 > kx0) ? b.x0 : kx0;
      r.y0 = (b.y0 > ky0) ? b.y0 : ky0;
      r.x1 = (b.x1 < kx1) ? b.x1 : kx1;
      r.y1 = (b.y1 < ky1) ? b.y1 : ky1;
      return r;
   endfunction

   function automatic logic box_live(input box_type r);
      return (r.x1 > r.x0) && (r.y1 > r.y0);
   endfunction

   function automatic logic signed [16:0] dir_of(input logic [16:0] q, input logic neg);
      logic signed [16:0] m;
      m = (q > 17'd32768) ? 17'sd32768 : $signed(q);
      return neg ? -m : m;
   endfunction

   // effective clip, used during setup
   logic        clip_empty, eclip_empty;
   logic [15:0] vpx1, vpy1;
   assign clip_empty = ($signed(cx1) <= $signed(cx0)) || ($signed(cy1) <= $signed(cy0));
   assign vpx1       = {1'b0, vw_ff, 4'b0};
   assign vpy1       = {1'b0, vh_ff, 4'b0};
   assign eclip_empty = clip_empty && ((vw_ff == 11'd0) || (vh_ff == 11'd0));

   logic [15:0] scx0, scy0, scx1, scy1;
   assign scx0 = clip_empty ? 16'd0 : cx0;
   assign scy0 = clip_empty ? 16'd0 : cy0;
   assign scx1 = clip_empty ? vpx1 : cx1;
   assign scy1 = clip_empty ? vpy1 : cy1;

   logic [3:0] setup_mask;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         setup_mask[i] = box_live(clip_to(bar_box(kind_ff, 2'(i), fx, fy, gx, gy, tw),
                                          scx0, scy0, scx1, scy1));
      end
      if (kind_ff == KIND_FILL) begin
         setup_mask[3:1] = 3'b000;
      end
   end

   logic signed [16:0] ddx, ddy;
   assign ddx = 17'($signed(gx)) - 17'($signed(fx));
   assign ddy = 17'($signed(gy)) - 17'($signed(fy));

   // rect: next live bar, lowest first
   logic [1:0] bar_idx;
   box_type    bar_clip;
   always_comb begin
      if (mask_ff[0]) begin
         bar_idx = 2'd0;
      end else if (mask_ff[1]) begin
         bar_idx = 2'd1;
      end else if (mask_ff[2]) begin
         bar_idx = 2'd2;
      end else begin
         bar_idx = 2'd3;
      end
      bar_clip = clip_to(bar_box(kind_ff, bar_idx, fx, fy, gx, gy, tw),
                         ecx0_ff, ecy0_ff, ecx1_ff, ecy1_ff);
   end

   // multiplier operands
   logic [11:0]        half_w;
   logic [13:0]        outer_w;
   logic [12:0]        fringe_w;
   logic signed [16:0] nx, ny;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] mul_p;
   assign half_w   = (tw > 12'd16) ? tw : 12'd16;
   assign outer_w  = {2'b0, half_w} + {1'b0, fw, 1'b0};
   assign fringe_w = {fw, 1'b0};
   assign nx       = -diry_ff;
   assign ny       = dirx_ff;

   always_comb begin
      case (step_ff)
         3'd0: begin mul_a = $signed({2'b0, ax_ff}); mul_b = $signed({2'b0, ax_ff}); end
         3'd1: begin mul_a = $signed({2'b0, ay_ff}); mul_b = $signed({2'b0, ay_ff}); end
         3'd2: begin mul_a = 18'(nx); mul_b = $signed({6'b0, half_w}); end
         3'd3: begin mul_a = 18'(ny); mul_b = $signed({6'b0, half_w}); end
         3'd4: begin mul_a = 18'(nx); mul_b = $signed({4'b0, outer_w}); end
         3'd5: begin mul_a = 18'(ny); mul_b = $signed({4'b0, outer_w}); end
         3'd6: begin mul_a = 18'(dirx_ff); mul_b = $signed({5'b0, fringe_w}); end
         default: begin mul_a = 18'(diry_ff); mul_b = $signed({5'b0, fringe_w}); end
      endcase
      mul_p = mul_a * mul_b;
   end

   logic [32:0] sq_sum;
   assign sq_sum = sq_ff + mul_p[32:0];

   // line corners from the stored products
   logic signed [16:0] ohx, ohy, omx, omy, opx, opy;
   assign ohx = round_off($signed(prod_ff[0]));
   assign ohy = round_off($signed(prod_ff[1]));
   assign omx = round_off($signed(prod_ff[2]) - $signed(prod_ff[4]));
   assign omy = round_off($signed(prod_ff[3]) - $signed(prod_ff[5]));
   assign opx = round_off($signed(prod_ff[2]) + $signed(prod_ff[4]));
   assign opy = round_off($signed(prod_ff[3]) + $signed(prod_ff[5]));

   logic [31:0] pa, pb, pc, pd, poa, pob, poc, pod;
   assign pa  = {corner(fy, ohy, 1'b0), corner(fx, ohx, 1'b0)};
   assign pb  = {corner(gy, ohy, 1'b0), corner(gx, ohx, 1'b0)};
   assign pc  = {corner(gy, ohy, 1'b1), corner(gx, ohx, 1'b1)};
   assign pd  = {corner(fy, ohy, 1'b1), corner(fx, ohx, 1'b1)};
   assign poa = {corner(fy, omy, 1'b0), corner(fx, omx, 1'b0)};
   assign pob = {corner(gy, opy, 1'b0), corner(gx, opx, 1'b0)};
   assign poc = {corner(gy, omy, 1'b1), corner(gx, omx, 1'b1)};
   assign pod = {corner(fy, opy, 1'b1), corner(fx, opx, 1'b1)};

   logic        slot_free;
   logic        emit;
   logic        emit_last;
   logic [31:0] ev_a, ev_b, ev_c, ev_d;
   logic [3:0]  ev_mask;
   logic [63:0] eclip_now;
   logic        csr_wr;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign eclip_now = {ecy1_ff, ecx1_ff, ecy0_ff, ecx0_ff};
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in      = state_ff;
      in_in         = in_ff;
      kind_in       = kind_ff;
      ecx0_in       = ecx0_ff;
      ecy0_in       = ecy0_ff;
      ecx1_in       = ecx1_ff;
      ecy1_in       = ecy1_ff;
      mask_in       = mask_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      sgnx_in       = sgnx_ff;
      sgny_in       = sgny_ff;
      step_in       = step_ff;
      sq_in         = sq_ff;
      r_in          = r_ff;
      dirx_in       = dirx_ff;
      diry_in       = diry_ff;
      prod_in       = prod_ff;
      qidx_in       = qidx_ff;
      batch_open_in = batch_open_ff;
      cur_clip_in   = cur_clip_ff;
      vw_in         = vw_ff;
      vh_in         = vh_ff;
      req_tready    = 1'b0;
      arith_ctl     = '{start: 1'b0, op: OP_SQRT};
      arith_num     = '0;
      arith_den     = r_ff;
      emit          = 1'b0;
      emit_last     = 1'b0;
      ev_a          = pa;
      ev_b          = pb;
      ev_c          = pc;
      ev_d          = pd;
      ev_mask       = MASK_NONE;

      if (csr_wr) begin
         if (csr_paddr[2] == REG_VIEW_H) begin
            vh_in = csr_pwdata[10:0];
         end else begin
            vw_in = csr_pwdata[10:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               in_in    = req_tdata;
               kind_in  = kind_type'(req_tuser);
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ecx0_in = scx0;
            ecy0_in = scy0;
            ecx1_in = scx1;
            ecy1_in = scy1;
            ax_in   = ddx[16] ? 16'(-ddx) : ddx[15:0];
            ay_in   = ddy[16] ? 16'(-ddy) : ddy[15:0];
            sgnx_in = ddx[16];
            sgny_in = ddy[16];
            step_in = 3'd0;
            case (kind_ff)
               KIND_TEXT: begin
                  batch_open_in = 1'b0;
                  state_in      = ST_IDLE;
               end
               KIND_LINE: begin
                  // drop zero-length lines and lines with no visible viewport
                  if (eclip_empty || (ddx == 17'sd0 && ddy == 17'sd0)) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               default: begin
                  mask_in  = setup_mask;
                  state_in = (setup_mask == 4'b0000) ? ST_IDLE : ST_RECT;
               end
            endcase
         end
         ST_RECT: begin
            if (slot_free) begin
               emit      = 1'b1;
               ev_a      = {bar_clip.y0[15:0], bar_clip.x0[15:0]};
               ev_b      = {bar_clip.y0[15:0], bar_clip.x1[15:0]};
               ev_c      = {bar_clip.y1[15:0], bar_clip.x1[15:0]};
               ev_d      = {bar_clip.y1[15:0], bar_clip.x0[15:0]};
               mask_in   = mask_ff & ~(4'b0001 << bar_idx);
               emit_last = (mask_in == 4'b0000);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd0) begin
               sq_in = mul_p[32:0];
            end else if (step_ff == 3'd1) begin
               sq_in         = sq_sum;
               arith_ctl     = '{start: 1'b1, op: OP_SQRT};
               arith_num     = {1'b0, sq_sum, 16'b0};
               state_in      = ST_SQRT;
            end else begin
               prod_in[3'(step_ff - 3'd2)] = mul_p[31:0];
               if (step_ff == 3'd7) begin
                  qidx_in  = 3'd0;
                  state_in = ST_LINE;
               end
            end
         end
         ST_SQRT: begin
            if (arith_done) begin
               r_in      = arith_result;
               arith_ctl = '{start: 1'b1, op: OP_DIV};
               arith_num = {10'b0, {1'b0, ax_ff, 23'b0} + {16'b0, arith_result[ROOT_W-1:1]}};
               arith_den = arith_result;
               state_in  = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (arith_done) begin
               dirx_in   = dir_of(arith_result[16:0], sgnx_ff);
               arith_ctl = '{start: 1'b1, op: OP_DIV};
               arith_num = {10'b0, {1'b0, ay_ff, 23'b0} + {16'b0, r_ff[ROOT_W-1:1]}};
               arith_den = r_ff;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (arith_done) begin
               diry_in  = dir_of(arith_result[16:0], sgny_ff);
               step_in  = 3'd2;
               state_in = ST_MUL;
            end
         end
         ST_LINE: begin
            if (slot_free) begin
               emit = 1'b1;
               case (qidx_ff)
                  3'd0: begin
                     ev_a = pa; ev_b = pb; ev_c = pc; ev_d = pd; ev_mask = MASK_NONE;
                  end
                  3'd1: begin
                     ev_a = poa; ev_b = pob; ev_c = pb; ev_d = pa; ev_mask = MASK_FRINGE_A;
                  end
                  3'd2: begin
                     ev_a = pd; ev_b = pc; ev_c = poc; ev_d = pod; ev_mask = MASK_FRINGE_C;
                  end
                  3'd3: begin
                     ev_a = pod; ev_b = poa; ev_c = pa; ev_d = pd; ev_mask = MASK_FRINGE_A;
                  end
                  default: begin
                     ev_a = pb; ev_b = pob; ev_c = poc; ev_d = pc; ev_mask = MASK_FRINGE_B;
                  end
               endcase
               emit_last = (qidx_ff == 3'd4) || (qidx_ff == 3'd0 && fw == 12'd0);
               qidx_in   = qidx_ff + 3'd1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // output register: load on a new quad, drop on transfer
      out_data_in = out_data_ff;
      out_nb_in   = out_nb_ff;
      out_last_in = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_data_in   = {4'b0, ecy1_ff, ecx1_ff, ecy0_ff, ecx0_ff, tint, ev_mask,
                          ev_d, ev_c, ev_b, ev_a};
         out_nb_in     = !batch_open_ff || (cur_clip_ff != eclip_now);
         out_last_in   = emit_last;
         cur_clip_in   = eclip_now;
         batch_open_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         batch_open_ff <= 1'b0;
         cur_clip_ff   <= '0;
         vw_ff         <= VIEW_W_RESET;
         vh_ff         <= VIEW_H_RESET;
         step_ff       <= '0;
         qidx_ff       <= '0;
         mask_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         batch_open_ff <= batch_open_in;
         cur_clip_ff   <= cur_clip_in;
         vw_ff         <= vw_in;
         vh_ff         <= vh_in;
         step_ff       <= step_in;
         qidx_ff       <= qidx_in;
         mask_ff       <= mask_in;
      end
      in_ff       <= in_in;
      kind_ff     <= kind_in;
      ecx0_ff     <= ecx0_in;
      ecy0_ff     <= ecy0_in;
      ecx1_ff     <= ecx1_in;
      ecy1_ff     <= ecy1_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      sgnx_ff     <= sgnx_in;
      sgny_ff     <= sgny_in;
      sq_ff       <= sq_in;
      r_ff        <= r_in;
      dirx_ff     <= dirx_in;
      diry_ff     <= diry_in;
      prod_ff     <= prod_in;
      out_data_ff <= out_data_in;
      out_nb_ff   <= out_nb_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_nb_ff;
   assign rsp_tlast  = out_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_VIEW_H) ? {21'b0, vh_ff} : {21'b0, vw_ff};

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> (state_ff == ST_SQRT || state_ff == ST_DIVX || state_ff == ST_DIVY))
      else $error("arith result arrived outside a wait state");
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && arith_done) |-> arith_result != '0)
      else $error("zero length reached the normalize step");
   a_quad_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINE |-> qidx_ff <= 3'd4)
      else $error("line quad index out of range");

endmodule
`default_nettype wire
